// ===== rtl/pvd_pkg.sv =====
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types, form codes and masks for the prefix varint decoder.
// ----------------------------------------------------------------------------
package pvd_pkg;

    localparam int unsigned VALUE_W = 59;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned LEFT_W  = 3;

    // Lead byte markers (lead byte >> 3) and the full C3 lead byte
    localparam logic [4:0] MARK_27 = 5'h1C;
    localparam logic [4:0] MARK_35 = 5'h1D;
    localparam logic [4:0] MARK_59 = 5'h1E;
    localparam logic [7:0] LEAD_C3 = 8'hC3;

    typedef enum logic [2:0] {
        FORM_SHORT = 3'd0,
        FORM_C3    = 3'd1,
        FORM_14    = 3'd2,
        FORM_21    = 3'd3,
        FORM_27    = 3'd4,
        FORM_35    = 3'd5,
        FORM_59    = 3'd6
    } t_form;

    // Classification of a lead byte
    typedef struct packed {
        logic              single;  // complete 1-byte integer
        logic              bad;     // unrecognized marker
        t_form             form;
        logic [LEFT_W-1:0] more;    // continuation bytes still to come
    } t_lead;

    // One decoded integer
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   encoded_length;
        logic               bad_marker;
    } t_result;

    // Decoder state seen by the top level for checking
    typedef struct packed {
        logic [LEFT_W-1:0] bytes_left;
        logic [LEN_W-1:0]  length_so_far;
    } t_core_status;

    // Value mask of each form
    function automatic logic [VALUE_W-1:0] form_mask(input t_form form);
        logic [VALUE_W-1:0] m;
        begin
            case (form)
                FORM_SHORT: m = VALUE_W'(64'h7F);
                FORM_C3:    m = VALUE_W'(64'hFFFF);
                FORM_14:    m = VALUE_W'(64'h3FFF);
                FORM_21:    m = VALUE_W'(64'h1F_FFFF);
                FORM_27:    m = VALUE_W'(64'h07FF_FFFF);
                FORM_35:    m = VALUE_W'(64'h07_FFFF_FFFF);
                FORM_59:    m = VALUE_W'(64'h07FF_FFFF_FFFF_FFFF);
                default:    m = '0;
            endcase
            form_mask = m;
        end
    endfunction

endpackage

// ===== rtl/pvd_lead_decode.sv =====
// ----------------------------------------------------------------------------
// pvd_lead_decode
// Classifies a lead byte into its form and continuation byte count.
// ----------------------------------------------------------------------------
module pvd_lead_decode
    import pvd_pkg::*;
(
    input  logic [7:0] i_byte,
    output t_lead      o_lead
);

    logic [4:0] marker;

    assign marker = i_byte[7:3];

    always_comb begin
        o_lead = '{single: 1'b0, bad: 1'b0, form: FORM_SHORT, more: '0};
        if (!i_byte[7]) begin
            o_lead.single = 1'b1;
        end else if (i_byte == LEAD_C3) begin
            o_lead.form = FORM_C3;
            o_lead.more = LEFT_W'(2);
        end else begin
            case (marker) inside
                [5'h10:5'h17]: begin
                    o_lead.form = FORM_14;
                    o_lead.more = LEFT_W'(1);
                end
                [5'h18:5'h1B]: begin
                    o_lead.form = FORM_21;
                    o_lead.more = LEFT_W'(2);
                end
                MARK_27: begin
                    o_lead.form = FORM_27;
                    o_lead.more = LEFT_W'(3);
                end
                MARK_35: begin
                    o_lead.form = FORM_35;
                    o_lead.more = LEFT_W'(4);
                end
                MARK_59: begin
                    o_lead.form = FORM_59;
                    o_lead.more = LEFT_W'(7);
                end
                default: begin
                    o_lead.bad = 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== rtl/pvd_core.sv =====
// ----------------------------------------------------------------------------
// pvd_core
// Decode state and accumulator; shifts in one byte per transaction and
// produces a result on the last byte of each integer and on each bad marker.
// ----------------------------------------------------------------------------
module pvd_core
    import pvd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_fire,
    input  logic [7:0]   i_byte,
    output logic         o_push,
    output t_result      o_result,
    output t_core_status o_status
);

    t_lead              lead;
    t_form              r_form, n_form;
    logic [LEFT_W-1:0]  r_bytes_left, n_bytes_left;
    logic [LEN_W-1:0]   r_length, n_length;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [VALUE_W-1:0] shifted;

    pvd_lead_decode u_lead (
        .i_byte (i_byte),
        .o_lead (lead)
    );

    // Big-endian shift; bits above the widest form fall off
    assign shifted = {r_acc[VALUE_W-9:0], i_byte};

    // Next state and result
    always_comb begin
        n_form       = r_form;
        n_bytes_left = r_bytes_left;
        n_length     = r_length;
        n_acc        = r_acc;
        o_push       = 1'b0;
        o_result     = '{value: '0, encoded_length: LEN_W'(1), bad_marker: 1'b0};
        if (i_fire) begin
            if (r_bytes_left == '0) begin
                if (lead.single) begin
                    o_push               = 1'b1;
                    o_result.value       = VALUE_W'(i_byte[6:0]);
                end else if (lead.bad) begin
                    o_push               = 1'b1;
                    o_result.bad_marker  = 1'b1;
                    n_form               = FORM_SHORT;
                    n_length             = '0;
                end else begin
                    n_form       = lead.form;
                    n_acc        = VALUE_W'(i_byte);
                    n_length     = LEN_W'(1);
                    n_bytes_left = lead.more;
                end
            end else begin
                n_acc        = shifted;
                n_length     = r_length + LEN_W'(1);
                n_bytes_left = r_bytes_left - LEFT_W'(1);
                if (n_bytes_left == '0) begin
                    o_push                  = 1'b1;
                    o_result.value          = shifted & form_mask(r_form);
                    o_result.encoded_length = n_length;
                    n_form                  = FORM_SHORT;
                    n_length                = '0;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form       <= FORM_SHORT;
            r_bytes_left <= '0;
            r_length     <= '0;
        end else begin
            r_form       <= n_form;
            r_bytes_left <= n_bytes_left;
            r_length     <= n_length;
        end
    end

    // Accumulator, reloaded by every multi-byte lead byte
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_status = '{bytes_left: r_bytes_left, length_so_far: r_length};

endmodule

// ===== rtl/pvd_out_buf.sv =====
// ----------------------------------------------------------------------------
// pvd_out_buf
// Output register with one skid entry, so the decoder keeps taking bytes
// while a finished result waits downstream.
// ----------------------------------------------------------------------------
module pvd_out_buf
    import pvd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_skid_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload; the producer pushes only while the skid entry is empty
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_skid_full = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

endmodule

// ===== rtl/prefix_varint_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// prefix_varint_decoder_unit
// Decodes a byte stream of prefix-length variable integers, one byte per
// transaction, and emits one result per complete integer or bad marker.
// Result path: the last byte of an integer passes the input register, then
//   the result register, which raises o_valid (via the skid entry on a stall).
// Throughput: one byte per cycle while o_stall is low; the result register plus
//   one skid entry decouple the input from a stalled output.
// Reset: synchronous, active low; clears decode state and all valid flags.
// ----------------------------------------------------------------------------
module prefix_varint_decoder_unit
    import pvd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [VALUE_W-1:0] o_value,
    output logic [LEN_W-1:0]   o_encoded_length,
    output logic               o_bad_marker
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         skid_full;
    logic         fire;
    logic         push;
    t_result      result;
    t_result      out_result;
    t_core_status status;

    // Input register advances whenever the skid entry has room
    assign fire    = r_in_valid && !skid_full;
    assign o_stall = r_in_valid && skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    pvd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .o_push   (push),
        .o_result (result),
        .o_status (status)
    );

    pvd_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (result),
        .o_skid_full (skid_full),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (out_result)
    );

    assign o_value          = out_result.value;
    assign o_encoded_length = out_result.encoded_length;
    assign o_bad_marker     = out_result.bad_marker;

    // The skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_full |-> o_valid)
        else $error("skid entry full while output register empty");

    // Bad marker results carry a zero value and one byte
    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_marker |-> o_value == '0 && o_encoded_length == LEN_W'(1))
        else $error("bad marker result with nonzero value or length");

    // Normal results have one of the legal encoded lengths
    a_result_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_marker |->
            o_encoded_length == LEN_W'(1) || o_encoded_length == LEN_W'(2) ||
            o_encoded_length == LEN_W'(3) || o_encoded_length == LEN_W'(4) ||
            o_encoded_length == LEN_W'(5) || o_encoded_length == LEN_W'(8))
        else $error("illegal encoded length");

    // Mid-integer the byte count is running and never exceeds the longest form
    a_mid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.bytes_left != '0 |->
            status.length_so_far != '0 && status.length_so_far < LEN_W'(8))
        else $error("byte count out of step with remaining bytes");

endmodule

// ===== tb/tb_prefix_varint_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prefix_varint_decoder_unit
// Self-checking bench for the prefix varint decoder. Bytes are sent one per
// transaction. A behavioral decoder predicts each integer, and the results
// are compared in order. Directed integers cover every form at its largest
// value, some forms also at zero, and the bad markers. Random integers are
// mixed with noise bytes under random idling on both sides, plus a long
// output hold-off and an unthrottled tail.
// ----------------------------------------------------------------------------
module tb_prefix_varint_decoder_unit;
    import pvd_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 460;
    localparam int TOTAL_BYTES  = 650;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [7:0]         i_data_byte = 8'h00;
    logic               i_stall     = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [VALUE_W-1:0] o_value;
    logic [LEN_W-1:0]   o_encoded_length;
    logic               o_bad_marker;

    // Behavioral decoder state
    logic [LEFT_W-1:0]  dec_left  = '0;
    t_form              dec_form  = FORM_SHORT;
    logic [63:0]        dec_acc   = '0;
    logic [LEN_W-1:0]   dec_len   = '0;
    t_result            expected_q[$];

    int  errors      = 0;
    int  bytes_sent  = 0;
    int  cycles      = 0;
    bit  idle_en     = 1'b1;
    int  hold_token  = 0;
    int  hold_seen   = 0;
    int  hold_left   = 0;
    int  stall_left  = 0;

    prefix_varint_decoder_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_value          (o_value),
        .o_encoded_length (o_encoded_length),
        .o_bad_marker     (o_bad_marker)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Value bits kept by each form
    function automatic logic [63:0] value_mask(input t_form f);
        int bits;
        case (f)
            FORM_C3: bits = 16;
            FORM_14: bits = 14;
            FORM_21: bits = 21;
            FORM_27: bits = 27;
            FORM_35: bits = 35;
            FORM_59: bits = 59;
            default: bits = 7;
        endcase
        return (64'd1 << bits) - 64'd1;
    endfunction

    // Advance the behavioral decoder by one accepted byte
    task automatic predict_byte(input logic [7:0] b);
        t_result           r;
        logic [4:0]        mk;
        logic [LEFT_W-1:0] more;
        logic [63:0]       v;
        mk   = b[7:3];
        more = '0;
        r    = '0;
        if (dec_left == '0) begin
            if (!b[7]) begin
                r.value          = VALUE_W'(b[6:0]);
                r.encoded_length = LEN_W'(1);
                expected_q.push_back(r);
            end else begin
                if (b == LEAD_C3) begin
                    dec_form = FORM_C3; more = 3'd2;
                end else if (mk < 5'h18) begin
                    dec_form = FORM_14; more = 3'd1;
                end else if (mk < MARK_27) begin
                    dec_form = FORM_21; more = 3'd2;
                end else if (mk == MARK_27) begin
                    dec_form = FORM_27; more = 3'd3;
                end else if (mk == MARK_35) begin
                    dec_form = FORM_35; more = 3'd4;
                end else if (mk == MARK_59) begin
                    dec_form = FORM_59; more = 3'd7;
                end else begin
                    // unknown marker: error result, restart on next byte
                    dec_form         = FORM_SHORT;
                    dec_acc          = '0;
                    dec_len          = '0;
                    r.encoded_length = LEN_W'(1);
                    r.bad_marker     = 1'b1;
                    expected_q.push_back(r);
                end
                if (more != '0) begin
                    dec_acc  = {56'd0, b};
                    dec_len  = LEN_W'(1);
                    dec_left = more;
                end
            end
        end else begin
            dec_acc  = {dec_acc[55:0], b};
            dec_len  = dec_len + LEN_W'(1);
            dec_left = dec_left - LEFT_W'(1);
            if (dec_left == '0) begin
                v                = dec_acc & value_mask(dec_form);
                r.value          = v[VALUE_W-1:0];
                r.encoded_length = dec_len;
                expected_q.push_back(r);
                dec_form = FORM_SHORT;
                dec_acc  = '0;
                dec_len  = '0;
            end
        end
    endtask

    // One input transaction, with an optional random gap ahead of it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        predict_byte(b);
        bytes_sent++;
    endtask

    // Lead byte, then continuation bytes until the integer is complete
    task automatic send_integer(input logic [7:0] lead, input logic [7:0] fill,
                                input bit rand_fill);
        send_byte(lead);
        while (dec_left != '0)
            send_byte(rand_fill ? 8'($urandom_range(0, 255)) : fill);
    endtask

    // Integer of a random form or a bad marker lead, or now and then a noise byte
    task automatic send_random_integer();
        logic [7:0] lead;
        case ($urandom_range(0, 8))
            0: lead = 8'($urandom_range(8'h00, 8'h7F));
            1: lead = LEAD_C3;
            2: lead = 8'($urandom_range(8'h80, 8'hBF));
            3: lead = 8'($urandom_range(8'hC0, 8'hDF));
            4: lead = 8'($urandom_range(8'hE0, 8'hE7));
            5: lead = 8'($urandom_range(8'hE8, 8'hEF));
            6: lead = 8'($urandom_range(8'hF0, 8'hF7));
            7: lead = 8'($urandom_range(8'hF8, 8'hFF));
            default: lead = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 6) == 0)
            send_byte(8'($urandom_range(0, 255)));
        else
            send_integer(lead, 8'h00, 1'b1);
    endtask

    // Sender pauses until every expected result is in, then the pipe settles
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver side: long hold-off on request, else random stall bursts
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD - 1;
            i_stall   <= 1'b1;
        end else if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(1, 15) - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result value=%h len=%0d bad=%b",
                         $time, o_value, o_encoded_length, o_bad_marker);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_value !== exp_r.value) begin
                    $display("%0t: value expected %h actual %h",
                             $time, exp_r.value, o_value);
                    errors++;
                end
                if (o_encoded_length !== exp_r.encoded_length) begin
                    $display("%0t: encoded_length expected %0d actual %0d",
                             $time, exp_r.encoded_length, o_encoded_length);
                    errors++;
                end
                if (o_bad_marker !== exp_r.bad_marker) begin
                    $display("%0t: bad_marker expected %b actual %b",
                             $time, exp_r.bad_marker, o_bad_marker);
                    errors++;
                end
            end
        end
    end

    // Single-byte integers at both ends and the bad marker range ends
    task automatic test_single_bytes_and_markers();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hF8);
        send_byte(8'hFF);
    endtask

    // Every multi-byte form with all-ones content, plus all-zeros for the 14-bit and 59-bit forms
    task automatic test_form_extremes();
        send_integer(8'h80, 8'h00, 1'b0);
        send_integer(8'hBF, 8'hFF, 1'b0);
        send_integer(LEAD_C3, 8'hFF, 1'b0);
        send_integer(8'hDF, 8'hFF, 1'b0);
        send_integer(8'hE7, 8'hFF, 1'b0);
        send_integer(8'hEF, 8'hFF, 1'b0);
        send_integer(8'hF7, 8'hFF, 1'b0);
        send_integer(8'hF0, 8'h00, 1'b0);
        wait_drained();
    endtask

    // Random stream with idling on both sides
    task automatic test_random_stream();
        idle_en = 1'b1;
        while (bytes_sent < RANDOM_BYTES) send_random_integer();
    endtask

    // Receiver holds off long enough that the decoder stalls its input
    task automatic test_output_hold();
        idle_en = 1'b0;
        hold_token++;
        repeat (16) send_random_integer();
        wait_drained();
    endtask

    // Back-to-back transactions with no idling on either side
    task automatic test_unthrottled_tail();
        idle_en = 1'b0;
        while (bytes_sent < TOTAL_BYTES) send_random_integer();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_bytes_and_markers();
        test_form_extremes();
        test_random_stream();
        test_output_hold();
        test_unthrottled_tail();
        wait_drained();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pvd_pkg.sv
rtl/pvd_lead_decode.sv
rtl/pvd_core.sv
rtl/pvd_out_buf.sv
rtl/prefix_varint_decoder_unit.sv
tb/tb_prefix_varint_decoder_unit.sv
